// ===== src/indexed_min_heap_assert.svh =====
// assertion macros for the indexed min-heap
// used by the top level; expects i_clk and i_rst_n in scope
`ifndef INDEXED_MIN_HEAP_ASSERT_SVH
`define INDEXED_MIN_HEAP_ASSERT_SVH

// condition holds at every edge out of reset
`define IHP_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

// consequence holds in the same cycle as the antecedent
`define IHP_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequence holds in the cycle after the antecedent
`define IHP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/ihp_pkg.sv =====
// shared types and constants of the indexed min-heap
// no dependencies
package ihp_pkg;

    localparam int HEAP_AW       = 12;
    localparam int HEAP_DEPTH    = 1 << HEAP_AW;
    localparam int CNT_W         = HEAP_AW + 1;
    localparam int ORD_W         = 16;
    localparam int ORDINAL_SPACE = 1 << ORD_W;
    localparam int ICTR_W        = ORD_W + 1;
    localparam int VAL_W         = 32;

    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_DELETE = 2'd1;
    localparam logic [1:0] CMD_QUERY  = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_UNKNOWN = 2'd2;
    localparam logic [1:0] ST_EMPTY   = 2'd3;

    // one heap slot: value and zero-based ordinal
    typedef struct packed {
        logic signed [VAL_W-1:0] value;
        logic [ORD_W-1:0]        ord;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

endpackage

// ===== src/ihp_ram.sv =====
// generic simple dual-port ram, one write and one registered read per cycle
// no dependencies
module ihp_ram #(
    parameter int AW = 12,
    parameter int DW = 48
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);
    localparam int DEPTH = 1 << AW;

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ===== src/indexed_min_heap.sv =====
// top level of the indexed min-heap: command sequencer, heap ram and position map ram
// depends on ihp_pkg, ihp_ram and indexed_min_heap_assert.svh
//
// usage
//   input channel  : i_in_valid / o_in_ready carry one command item
//                    (i_command, i_value, i_ordinal)
//   output channel : o_out_valid / i_out_ready carry one result item per command
//                    (o_status, o_min_value, o_assigned_ordinal, o_entry_count)
//   one item at a time; a new command is taken only while the sequencer is idle
//   query  : reads the copy of slot zero; a full insert is rejected at accept
//   insert : climbs k levels from the new end slot, k at most 12, then writes the entry
//   delete : map lookup, slot check, last entry fills the hole, sift-up then sift-down
//   the heap ram has one read and one write port with a registered read; sift-up
//   issues one parent read per level, sift-down reads left then right child
//   a finished result sits in an output register; the next item is taken while it
//   waits, and the block holds a newer result until the receiver takes the old one
//   reset (synchronous, active low) empties the heap and restarts ordinals at 1;
//   ram contents are not cleared, stale entries are masked by occupancy and the
//   ordinal check on delete
module indexed_min_heap (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [1:0]                          i_command,
    input  logic signed [ihp_pkg::VAL_W-1:0]    i_value,
    input  logic [ihp_pkg::ICTR_W-1:0]          i_ordinal,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [1:0]                          o_status,
    output logic signed [ihp_pkg::VAL_W-1:0]    o_min_value,
    output logic [ihp_pkg::ICTR_W-1:0]          o_assigned_ordinal,
    output logic [ihp_pkg::CNT_W-1:0]           o_entry_count
);
    import ihp_pkg::*;

    `include "indexed_min_heap_assert.svh"

    // sequencer states
    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_DEL_MAP  = 4'd1;
    localparam logic [3:0] S_DEL_CHK  = 4'd2;
    localparam logic [3:0] S_DEL_LAST = 4'd3;
    localparam logic [3:0] S_UP_RD    = 4'd4;
    localparam logic [3:0] S_UP_CMP   = 4'd5;
    localparam logic [3:0] S_DN_RDL   = 4'd6;
    localparam logic [3:0] S_DN_RDR   = 4'd7;
    localparam logic [3:0] S_DN_CMP   = 4'd8;
    localparam logic [3:0] S_PLACE    = 4'd9;
    localparam logic [3:0] S_DONE     = 4'd10;

    // control state
    logic [3:0]          r_state, n_state;
    logic [CNT_W-1:0]    r_occ, n_occ;
    logic [ICTR_W-1:0]   r_ictr, n_ictr;
    logic                r_out_valid, n_out_valid;

    // working registers
    t_entry              r_e, n_e;          // entry being moved through the heap
    logic [HEAP_AW-1:0]  r_h, n_h;          // current hole slot
    t_entry              r_left, n_left;    // left child during sift-down
    logic [ORD_W-1:0]    r_ord0, n_ord0;    // zero-based ordinal of a delete
    logic                r_del, n_del;      // delete runs sift-down after sift-up
    logic [1:0]          r_status, n_status;
    logic [ICTR_W-1:0]   r_assigned, n_assigned;
    logic signed [VAL_W-1:0] r_min, n_min;  // copy of slot zero

    // output registers
    logic [1:0]              r_o_status, n_o_status;
    logic signed [VAL_W-1:0] r_o_min, n_o_min;
    logic [ICTR_W-1:0]       r_o_assigned, n_o_assigned;
    logic [CNT_W-1:0]        r_o_count, n_o_count;

    // ram ports
    logic                heap_we, heap_re;
    logic [HEAP_AW-1:0]  heap_waddr, heap_raddr;
    t_entry              heap_wdata, heap_rdata;
    logic [ENTRY_W-1:0]  heap_rdata_raw;
    logic                map_we, map_re;
    logic [ORD_W-1:0]    map_waddr, map_raddr;
    logic [HEAP_AW-1:0]  map_wdata, map_rdata;

    // handshake and decode
    logic                in_accept;
    logic                ins_full;
    logic                out_free;

    // address arithmetic
    logic [HEAP_AW-1:0]  parent_h, parent_p;
    logic [CNT_W-1:0]    left_h, right_h;
    logic                right_ok;
    logic                pick_right;
    t_entry              best;
    logic [HEAP_AW-1:0]  best_idx;
    logic [CNT_W-1:0]    next_left;
    logic [HEAP_AW-1:0]  last_slot;

    ihp_ram #(.AW(HEAP_AW), .DW(ENTRY_W)) u_heap_ram (
        .i_clk   (i_clk),
        .i_we    (heap_we),
        .i_waddr (heap_waddr),
        .i_wdata (heap_wdata),
        .i_re    (heap_re),
        .i_raddr (heap_raddr),
        .o_rdata (heap_rdata_raw)
    );
    assign heap_rdata = t_entry'(heap_rdata_raw);

    ihp_ram #(.AW(ORD_W), .DW(HEAP_AW)) u_map_ram (
        .i_clk   (i_clk),
        .i_we    (map_we),
        .i_waddr (map_waddr),
        .i_wdata (map_wdata),
        .i_re    (map_re),
        .i_raddr (map_raddr),
        .o_rdata (map_rdata)
    );

    assign o_in_ready = (r_state == S_IDLE);
    assign in_accept  = i_in_valid && o_in_ready;
    assign ins_full   = (r_occ == CNT_W'(HEAP_DEPTH)) || (r_ictr == ICTR_W'(ORDINAL_SPACE));
    assign out_free   = !r_out_valid || i_out_ready;

    // parent of the hole and of that parent (sift-up issues one level ahead)
    assign parent_h   = (r_h - 1'b1) >> 1;
    assign parent_p   = (parent_h - 1'b1) >> 1;
    assign left_h     = {r_h, 1'b1};
    assign right_h    = left_h + 1'b1;
    assign right_ok   = (right_h < r_occ);
    // ties go to the left child
    assign pick_right = right_ok && (heap_rdata.value < r_left.value);
    assign best       = pick_right ? heap_rdata : r_left;
    assign best_idx   = pick_right ? right_h[HEAP_AW-1:0] : left_h[HEAP_AW-1:0];
    assign next_left  = {best_idx, 1'b1};
    assign last_slot  = HEAP_AW'(r_occ - 1'b1);

    always_comb begin
        n_state      = r_state;
        n_occ        = r_occ;
        n_ictr       = r_ictr;
        n_out_valid  = r_out_valid;
        n_e          = r_e;
        n_h          = r_h;
        n_left       = r_left;
        n_ord0       = r_ord0;
        n_del        = r_del;
        n_status     = r_status;
        n_assigned   = r_assigned;
        n_min        = r_min;
        n_o_status   = r_o_status;
        n_o_min      = r_o_min;
        n_o_assigned = r_o_assigned;
        n_o_count    = r_o_count;

        heap_we    = 1'b0;
        heap_waddr = r_h;
        heap_wdata = r_e;
        heap_re    = 1'b0;
        heap_raddr = r_h;
        map_we     = 1'b0;
        map_waddr  = r_e.ord;
        map_wdata  = r_h;
        // position lookup for a delete starts in the accept cycle
        map_re     = in_accept;
        map_raddr  = ORD_W'(i_ordinal - 1'b1);

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    n_status   = ST_OK;
                    n_assigned = '0;
                    n_ord0     = ORD_W'(i_ordinal - 1'b1);
                    case (i_command)
                        CMD_INSERT: begin
                            if (ins_full) begin
                                n_status = ST_FULL;
                                n_state  = S_DONE;
                            end else begin
                                n_e.value  = i_value;
                                n_e.ord    = r_ictr[ORD_W-1:0];
                                n_h        = r_occ[HEAP_AW-1:0];
                                n_occ      = r_occ + 1'b1;
                                n_ictr     = r_ictr + 1'b1;
                                n_assigned = r_ictr + 1'b1;
                                n_del      = 1'b0;
                                n_state    = S_UP_RD;
                            end
                        end
                        CMD_DELETE: begin
                            if (r_occ == '0) begin
                                n_status = ST_EMPTY;
                                n_state  = S_DONE;
                            end else if (i_ordinal == '0 || i_ordinal > r_ictr) begin
                                n_status = ST_UNKNOWN;
                                n_state  = S_DONE;
                            end else begin
                                n_del   = 1'b1;
                                n_state = S_DEL_MAP;
                            end
                        end
                        default: begin
                            if (r_occ == '0) begin
                                n_status = ST_EMPTY;
                            end
                            n_state = S_DONE;
                        end
                    endcase
                end
            end

            S_DEL_MAP: begin
                if ({1'b0, map_rdata} >= r_occ) begin
                    n_status = ST_UNKNOWN;
                    n_state  = S_DONE;
                end else begin
                    heap_re    = 1'b1;
                    heap_raddr = map_rdata;
                    n_h        = map_rdata;
                    n_state    = S_DEL_CHK;
                end
            end

            S_DEL_CHK: begin
                if (heap_rdata.ord != r_ord0) begin
                    n_status = ST_UNKNOWN;
                    n_state  = S_DONE;
                end else begin
                    n_occ = r_occ - 1'b1;
                    if (r_h == last_slot) begin
                        n_state = S_DONE;
                    end else begin
                        // last entry fills the hole
                        heap_re    = 1'b1;
                        heap_raddr = last_slot;
                        n_state    = S_DEL_LAST;
                    end
                end
            end

            S_DEL_LAST: begin
                n_e     = heap_rdata;
                n_state = S_UP_RD;
            end

            S_UP_RD: begin
                if (r_h == '0) begin
                    n_state = r_del ? S_DN_RDL : S_PLACE;
                end else begin
                    heap_re    = 1'b1;
                    heap_raddr = parent_h;
                    n_state    = S_UP_CMP;
                end
            end

            S_UP_CMP: begin
                if (heap_rdata.value > r_e.value) begin
                    // parent moves down into the hole
                    heap_we    = 1'b1;
                    heap_waddr = r_h;
                    heap_wdata = heap_rdata;
                    map_we     = 1'b1;
                    map_waddr  = heap_rdata.ord;
                    map_wdata  = r_h;
                    n_h        = parent_h;
                    if (parent_h == '0) begin
                        n_state = r_del ? S_DN_RDL : S_PLACE;
                    end else begin
                        heap_re    = 1'b1;
                        heap_raddr = parent_p;
                    end
                end else begin
                    n_state = r_del ? S_DN_RDL : S_PLACE;
                end
            end

            S_DN_RDL: begin
                if (left_h >= r_occ) begin
                    n_state = S_PLACE;
                end else begin
                    heap_re    = 1'b1;
                    heap_raddr = left_h[HEAP_AW-1:0];
                    n_state    = S_DN_RDR;
                end
            end

            S_DN_RDR: begin
                n_left     = heap_rdata;
                heap_re    = right_ok;
                heap_raddr = right_h[HEAP_AW-1:0];
                n_state    = S_DN_CMP;
            end

            S_DN_CMP: begin
                if (r_e.value > best.value) begin
                    // smaller child moves up into the hole
                    heap_we    = 1'b1;
                    heap_waddr = r_h;
                    heap_wdata = best;
                    map_we     = 1'b1;
                    map_waddr  = best.ord;
                    map_wdata  = r_h;
                    n_h        = best_idx;
                    if (next_left >= r_occ) begin
                        n_state = S_PLACE;
                    end else begin
                        heap_re    = 1'b1;
                        heap_raddr = next_left[HEAP_AW-1:0];
                        n_state    = S_DN_RDR;
                    end
                end else begin
                    n_state = S_PLACE;
                end
            end

            S_PLACE: begin
                heap_we    = 1'b1;
                heap_waddr = r_h;
                heap_wdata = r_e;
                map_we     = 1'b1;
                map_waddr  = r_e.ord;
                map_wdata  = r_h;
                n_state    = S_DONE;
            end

            S_DONE: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_o_status   = r_status;
                    n_o_min      = (r_occ == '0) ? '0 : r_min;
                    n_o_assigned = r_assigned;
                    n_o_count    = r_occ;
                    n_state      = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase

        // slot zero holds the minimum; track every write to it
        if (heap_we && heap_waddr == '0) begin
            n_min = heap_wdata.value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_occ       <= '0;
            r_ictr      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_occ       <= n_occ;
            r_ictr      <= n_ictr;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_e          <= n_e;
        r_h          <= n_h;
        r_left       <= n_left;
        r_ord0       <= n_ord0;
        r_del        <= n_del;
        r_status     <= n_status;
        r_assigned   <= n_assigned;
        r_min        <= n_min;
        r_o_status   <= n_o_status;
        r_o_min      <= n_o_min;
        r_o_assigned <= n_o_assigned;
        r_o_count    <= n_o_count;
    end

    assign o_out_valid        = r_out_valid;
    assign o_status           = r_o_status;
    assign o_min_value        = r_o_min;
    assign o_assigned_ordinal = r_o_assigned;
    assign o_entry_count      = r_o_count;

    // counters stay within the store sizes
    `IHP_ASSERT_ALWAYS(a_count_bound,
        (r_occ <= CNT_W'(HEAP_DEPTH)) && (r_ictr <= ICTR_W'(ORDINAL_SPACE)),
        "occupancy or ordinal counter out of range")
    // every slot write updates the position map of the same entry, inside the heap
    `IHP_ASSERT_SAME(a_write_pair, heap_we || map_we,
        heap_we && map_we && (map_wdata == heap_waddr) && (map_waddr == heap_wdata.ord)
            && ({1'b0, heap_waddr} < r_occ),
        "heap and position map writes out of step")
    // an insert with room grows the heap by one
    `IHP_ASSERT_NEXT(a_insert_grow, in_accept && (i_command == CMD_INSERT) && !ins_full,
        (r_occ == CNT_W'($past(r_occ) + 1'b1)) && (r_ictr == ICTR_W'($past(r_ictr) + 1'b1)),
        "insert did not grow the heap")

endmodule
